### hdl/psfr_pkg.sv
// Shared types and constants of the particle sensor frame receiver.
package psfr_pkg;

  localparam int FRAME_LEN_DEF  = 32;
  localparam int DATA_WORDS_DEF = 12;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_LEN_ERR    = 2'd2,
    ST_SUM_ERR    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HALF = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_fault;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        last;
  } out_word_t;

  // frame outcome handed from parser to emitter
  typedef struct packed {
    logic    valid;
    status_t status;
  } ev_t;

endpackage

### hdl/particle_sensor_frame_receiver.sv
// Top level of the particle sensor frame receiver.
//
// Input channel: one received serial byte per word (in_word.rx_byte) with a
// receive fault flag (in_word.rx_fault); taken when in_valid is high and
// in_stall is low. Bytes are taken one per cycle while in_stall stays low.
// Result channel: out_word carries status, word index, word value and last;
// taken when out_valid is high and out_stall is low.
// A frame that passes its length and checksum checks gives DATA_WORDS results
// in a burst; a failed frame or a receive fault gives one error
// result with last set. The first result sits in the output register in the
// cycle after the byte that caused it.
// Throughput is one byte per cycle; a byte that would raise a new result is
// held off (in_stall) only while an earlier burst is still draining from the
// word shifter or the output register is full and stalled. Other bytes keep
// flowing during a burst.
// Reset (rst_n low, synchronous) returns the parser to header hunt and
// empties the output side. A stalled result holds steady on out_word.
module particle_sensor_frame_receiver #(
  parameter int FRAME_LEN  = psfr_pkg::FRAME_LEN_DEF,
  parameter int DATA_WORDS = psfr_pkg::DATA_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psfr_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output psfr_pkg::out_word_t out_word
);

  psfr_pkg::ev_t               ev;
  logic [DATA_WORDS-1:0][15:0] ev_words;
  logic                        ev_ready;

  // byte parser: header hunt, frame state, checks at last byte
  psfr_parser #(
    .FRAME_LEN  (FRAME_LEN),
    .DATA_WORDS (DATA_WORDS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .ev_ready (ev_ready),
    .ev       (ev),
    .ev_words (ev_words)
  );

  // result side: snapshot of the words and one result per cycle unless stalled
  psfr_emitter #(
    .DATA_WORDS (DATA_WORDS)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .ev_words  (ev_words),
    .ev_ready  (ev_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### hdl/psfr_parser.sv
// Header hunt, frame collection, checksum and length check.
module psfr_parser #(
  parameter int FRAME_LEN  = psfr_pkg::FRAME_LEN_DEF,
  parameter int DATA_WORDS = psfr_pkg::DATA_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  psfr_pkg::in_word_t           in_word,
  input  logic                         ev_ready,
  output psfr_pkg::ev_t                ev,
  output logic [DATA_WORDS-1:0][15:0]  ev_words
);

  localparam int CNT_W = $clog2(FRAME_LEN);

  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] chk;
  } acc_t;

  psfr_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      len_r, len_nxt;
  acc_t             acc_r, acc_nxt;
  logic [DATA_WORDS-1:0][15:0] data_r, data_nxt;

  logic        acc_ok;
  logic        at_end;
  logic        needs_ev;
  logic [7:0]  b;
  logic [16:0] pos;
  logic [15:0] len_full;

  // one frame byte into the running sum or the stored checksum
  function automatic acc_t account(acc_t a, logic [16:0] sum_len, logic [16:0] p,
                                   logic [7:0] d);
    acc_t r;
    r = a;
    if (p < sum_len) r.sum = a.sum + 16'(d);
    if (p == sum_len) r.chk[15:8] = d;
    if (p == sum_len + 17'd1) r.chk[7:0] = d;
    return r;
  endfunction

  assign b        = in_word.rx_byte;
  assign pos      = 17'(cnt_r);
  assign len_full = {len_r[15:8], b};
  assign at_end   = (phase_r == psfr_pkg::PH_BODY) && (cnt_r == CNT_W'(FRAME_LEN - 1));
  assign needs_ev = in_word.rx_fault || at_end;
  assign in_stall = needs_ev && !ev_ready;
  assign acc_ok   = in_valid && !in_stall;

  // phase control: header hunt, second header byte, frame body
  always_comb begin
    phase_nxt = phase_r;
    if (acc_ok) begin
      if (in_word.rx_fault) begin
        phase_nxt = psfr_pkg::PH_HUNT;
      end else begin
        case (phase_r)
          psfr_pkg::PH_HUNT: begin
            if (b == psfr_pkg::HDR_FIRST) phase_nxt = psfr_pkg::PH_HALF;
          end
          psfr_pkg::PH_HALF: begin
            phase_nxt = (b == psfr_pkg::HDR_SECOND) ? psfr_pkg::PH_BODY : psfr_pkg::PH_HUNT;
          end
          psfr_pkg::PH_BODY: begin
            if (at_end) phase_nxt = psfr_pkg::PH_HUNT;
          end
          default: phase_nxt = psfr_pkg::PH_HUNT;
        endcase
      end
    end
  end

  // datapath and frame outcome
  always_comb begin
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    data_nxt  = data_r;
    ev.valid  = 1'b0;
    ev.status = psfr_pkg::ST_OK;
    if (acc_ok) begin
      if (in_word.rx_fault) begin
        cnt_nxt   = '0;
        ev.valid  = 1'b1;
        ev.status = psfr_pkg::ST_INCOMPLETE;
      end else begin
        case (phase_r)
          psfr_pkg::PH_HALF: begin
            if (b == psfr_pkg::HDR_SECOND) begin
              cnt_nxt = CNT_W'(2);
              len_nxt = '0;
              acc_nxt = '0;
            end
          end
          psfr_pkg::PH_BODY: begin
            if (pos == 17'd2) begin
              len_nxt = {b, 8'h00};
            end else if (pos == 17'd3) begin
              // header and length bytes are only known as a whole here
              len_nxt = len_full;
              acc_nxt = account(acc_nxt, 17'(len_full) + 17'd2, 17'd0, psfr_pkg::HDR_FIRST);
              acc_nxt = account(acc_nxt, 17'(len_full) + 17'd2, 17'd1, psfr_pkg::HDR_SECOND);
              acc_nxt = account(acc_nxt, 17'(len_full) + 17'd2, 17'd2, len_r[15:8]);
              acc_nxt = account(acc_nxt, 17'(len_full) + 17'd2, 17'd3, b);
            end else begin
              acc_nxt = account(acc_r, 17'(len_r) + 17'd2, pos, b);
            end
            for (int i = 0; i < DATA_WORDS; i++) begin
              if (32'(cnt_r) == 4 + 2 * i) data_nxt[i][15:8] = b;
              if (32'(cnt_r) == 5 + 2 * i) data_nxt[i][7:0]  = b;
            end
            if (at_end) begin
              cnt_nxt  = '0;
              ev.valid = 1'b1;
              if (17'(len_nxt) + 17'd4 > 17'(FRAME_LEN)) begin
                ev.status = psfr_pkg::ST_LEN_ERR;
              end else if (acc_nxt.sum != acc_nxt.chk) begin
                ev.status = psfr_pkg::ST_SUM_ERR;
              end
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign ev_words = data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= psfr_pkg::PH_HUNT;
      cnt_r   <= '0;
      len_r   <= '0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### hdl/psfr_emitter.sv
// Result register and word burst shifter.
module psfr_emitter #(
  parameter int DATA_WORDS = psfr_pkg::DATA_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psfr_pkg::ev_t                ev,
  input  logic [DATA_WORDS-1:0][15:0]  ev_words,
  output logic                         ev_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output psfr_pkg::out_word_t          out_word
);

  localparam int IDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  logic                        busy_r, busy_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [DATA_WORDS-1:0][15:0] snap_r, snap_nxt;
  logic                        out_valid_r, out_valid_nxt;
  psfr_pkg::out_word_t         out_word_r, out_word_nxt;
  logic                        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign ev_ready = !busy_r && out_free;

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    snap_nxt      = snap_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (ev.valid) begin
      out_valid_nxt = 1'b1;
      if (ev.status == psfr_pkg::ST_OK) begin
        out_word_nxt = '{status: psfr_pkg::ST_OK, word_index: 4'd0,
                         word_value: ev_words[0], last: (DATA_WORDS == 1)};
        busy_nxt     = (DATA_WORDS > 1);
        idx_nxt      = IDX_W'(1);
        // word 0 leaves now, the rest queue up behind it
        for (int i = 0; i < DATA_WORDS - 1; i++) snap_nxt[i] = ev_words[i + 1];
        snap_nxt[DATA_WORDS-1] = '0;
      end else begin
        out_word_nxt = '{status: ev.status, word_index: 4'd0, word_value: 16'd0, last: 1'b1};
      end
    end else if (busy_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '{status: psfr_pkg::ST_OK, word_index: 4'(idx_r),
                        word_value: snap_r[0], last: (idx_r == IDX_W'(DATA_WORDS - 1))};
      busy_nxt      = (idx_r != IDX_W'(DATA_WORDS - 1));
      idx_nxt       = idx_r + IDX_W'(1);
      for (int i = 0; i < DATA_WORDS - 1; i++) snap_nxt[i] = snap_r[i + 1];
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r     <= snap_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
